/* hw/rtl/fcc_pkg.sv */
// types, codes and constants shared by the flash command controller
package fcc_pkg;

  localparam int PAGE_BYTES = 128;
  localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);

  localparam int REG_ADDR_W = 16;
  localparam int WORD_W     = 32;
  localparam int MEM_ADDR_W = 24;
  localparam int FLASH_AW   = 16;
  localparam int LEN_W      = 25;
  localparam int DATA_W     = 64;
  localparam int OFFSET_W   = 23;
  localparam int OP_W       = 8;

  localparam int S_TDATA_W = 152;
  localparam int M_TDATA_W = 136;
  localparam int S_TUSER_W = 2;
  localparam int M_TUSER_W = 4;

  typedef enum logic [1:0] {
    KIND_STATUS_READ  = 2'd0,
    KIND_CMD_WRITE    = 2'd1,
    KIND_DMA_TO_FLASH = 2'd2,
    KIND_DMA_TO_MEM   = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ACT_NONE       = 3'd0,
    ACT_READ_DATA  = 3'd1,
    ACT_ERASE      = 3'd2,
    ACT_PROGRAM    = 3'd3,
    ACT_STATUS_DMA = 3'd4,
    ACT_ARRAY_READ = 3'd5,
    ACT_IGNORED    = 3'd6
  } action_t;

  typedef enum logic [4:0] {
    MODE_IDLE    = 5'b00001,
    MODE_READ    = 5'b00010,
    MODE_ERASE   = 5'b00100,
    MODE_PROGRAM = 5'b01000,
    MODE_STATUS  = 5'b10000
  } mode_t;

  localparam logic [OP_W-1:0] CMD_NOP         = 8'h00;
  localparam logic [OP_W-1:0] CMD_PAGE_SELECT = 8'h4b;
  localparam logic [OP_W-1:0] CMD_ERASE_MODE  = 8'h78;
  localparam logic [OP_W-1:0] CMD_ERASE_PAGE  = 8'ha5;
  localparam logic [OP_W-1:0] CMD_PROG_MODE   = 8'hb4;
  localparam logic [OP_W-1:0] CMD_EXECUTE     = 8'hd2;
  localparam logic [OP_W-1:0] CMD_STATUS_MODE = 8'he1;
  localparam logic [OP_W-1:0] CMD_READ_MODE   = 8'hf0;

  localparam logic [DATA_W-1:0] STATUS_ERASE_MODE = 64'h1111800800c20000;
  localparam logic [DATA_W-1:0] STATUS_ERASE_PAGE = 64'h1111800400c20000;
  localparam logic [DATA_W-1:0] STATUS_STATUS     = 64'h1111800100c20001;
  localparam logic [DATA_W-1:0] STATUS_READ       = 64'h11118004f0000000;

  typedef struct packed {
    kind_t                  kind;
    logic [REG_ADDR_W-1:0]  reg_address;
    logic [WORD_W-1:0]      cmd_value;
    logic [WORD_W-1:0]      byte_mask;
    logic [MEM_ADDR_W-1:0]  mem_address;
    logic [FLASH_AW-1:0]    flash_address;
    logic [LEN_W-1:0]       xfer_length;
  } in_item_t;

  typedef struct packed {
    logic                   error;
    action_t                action;
    logic [DATA_W-1:0]      data_word;
    logic [OFFSET_W-1:0]    flash_offset;
    logic [MEM_ADDR_W-1:0]  mem_pointer;
    logic [LEN_W-1:0]       out_length;
  } result_t;

endpackage

/* hw/rtl/flash_command_controller.sv */
// flash command controller top level: streams, config register and pipeline
// an accepted request waits in the input reg, and its result is then registered in the result reg
// one request per cycle while the output is not stalled; state updates as each request leaves the input reg
// a stalled output holds its result while the input reg can still take one request
// rst (sync, active high) sets idle mode, clears status, page offset, staging pointer
// rst also sets flash_enabled to 1 and empties both pipeline registers
module flash_command_controller (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // reg_address, cmd_value, byte_mask, mem_address, flash_address, xfer_length, zero pad
  input  logic [fcc_pkg::S_TDATA_W-1:0]   s_tdata,
  // kind
  input  logic [fcc_pkg::S_TUSER_W-1:0]   s_tuser,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // data_word, flash_offset, mem_pointer, out_length
  output logic [fcc_pkg::M_TDATA_W-1:0]   m_tdata,
  // error, action
  output logic [fcc_pkg::M_TUSER_W-1:0]   m_tuser,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic                            cfg_data
);

  logic              flash_enabled;
  fcc_pkg::in_item_t s_item;
  fcc_pkg::in_item_t item;
  logic              item_valid;
  logic              out_ready;
  logic              advance;
  fcc_pkg::result_t  core_result;
  fcc_pkg::result_t  result;
  logic              accessed;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      flash_enabled <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      flash_enabled <= cfg_data;
    end
  end

  assign s_item.kind          = fcc_pkg::kind_t'(s_tuser[1:0]);
  assign s_item.reg_address   = s_tdata[15:0];
  assign s_item.cmd_value     = s_tdata[47:16];
  assign s_item.byte_mask     = s_tdata[79:48];
  assign s_item.mem_address   = s_tdata[103:80];
  assign s_item.flash_address = s_tdata[119:104];
  assign s_item.xfer_length   = s_tdata[144:120];

  assign advance = item_valid && out_ready;

  fcc_in_stage u_in_stage (
    .clk        (clk),
    .rst        (rst),
    .s_valid    (s_tvalid),
    .s_ready    (s_tready),
    .s_item     (s_item),
    .item_valid (item_valid),
    .item       (item),
    .take       (advance)
  );

  fcc_core u_core (
    .clk           (clk),
    .rst           (rst),
    .flash_enabled (flash_enabled),
    .advance       (advance),
    .item          (item),
    .result        (core_result),
    .accessed      (accessed)
  );

  fcc_out_stage u_out_stage (
    .clk       (clk),
    .rst       (rst),
    .load      (item_valid),
    .result_in (core_result),
    .ready     (out_ready),
    .m_valid   (m_tvalid),
    .m_ready   (m_tready),
    .result    (result)
  );

  assign m_tdata = {result.out_length, result.mem_pointer, result.flash_offset,
                    result.data_word};
  assign m_tuser = {result.action, result.error};

  a_advance_gives_result: assert property (@(posedge clk) disable iff (rst)
    advance |=> m_tvalid)
    else $error("result register not loaded after a request advanced");

  a_accept_fills_input: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> item_valid)
    else $error("accepted request did not reach the input register");

  a_accessed_sticky: assert property (@(posedge clk) disable iff (rst)
    accessed |=> accessed)
    else $error("accessed flag cleared without reset");

  a_error_no_action: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && result.error) |-> (result.action == fcc_pkg::ACT_NONE))
    else $error("rejected access carries an action");

endmodule

/* hw/rtl/fcc_in_stage.sv */
// input register holding one request ahead of the decode
module fcc_in_stage (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_valid,
  output logic              s_ready,
  input  fcc_pkg::in_item_t s_item,
  output logic              item_valid,
  output fcc_pkg::in_item_t item,
  input  logic              take
);

  assign s_ready = !item_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (s_ready) begin
      item_valid <= s_valid;
    end
    if (s_valid && s_ready) begin
      item <= s_item;
    end
  end

endmodule

/* hw/rtl/fcc_core.sv */
// command decode, chip state registers and result forming
module fcc_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              flash_enabled,
  input  logic              advance,
  input  fcc_pkg::in_item_t item,
  output fcc_pkg::result_t  result,
  output logic              accessed
);

  fcc_pkg::mode_t                    mode, mode_next;
  logic [fcc_pkg::DATA_W-1:0]        status_reg, status_reg_next;
  logic [fcc_pkg::OFFSET_W-1:0]      page_offset, page_offset_next;
  logic [fcc_pkg::MEM_ADDR_W-1:0]    staging_pointer, staging_pointer_next;
  logic                              accessed_next;

  logic                              rejected;
  logic [fcc_pkg::WORD_W-1:0]        cmd;
  logic [fcc_pkg::OP_W-1:0]          op;
  logic [fcc_pkg::OFFSET_W-1:0]      page_sel;

  assign rejected = !flash_enabled || (item.reg_address != '0);
  assign cmd      = item.cmd_value & item.byte_mask;
  assign op       = cmd[fcc_pkg::WORD_W-1 -: fcc_pkg::OP_W];
  assign page_sel = fcc_pkg::OFFSET_W'(cmd[15:0]) << fcc_pkg::PAGE_SHIFT;

  always_comb begin
    mode_next            = mode;
    status_reg_next      = status_reg;
    page_offset_next     = page_offset;
    staging_pointer_next = staging_pointer;
    accessed_next        = accessed;
    result               = '0;
    result.action        = fcc_pkg::ACT_NONE;

    unique case (item.kind)
      fcc_pkg::KIND_STATUS_READ: begin
        if (rejected) begin
          result.error = 1'b1;
        end else begin
          accessed_next    = 1'b1;
          result.action    = fcc_pkg::ACT_READ_DATA;
          result.data_word = {32'd0, status_reg[63:32]};
        end
      end
      fcc_pkg::KIND_CMD_WRITE: begin
        if (rejected) begin
          result.error = 1'b1;
        end else begin
          accessed_next = 1'b1;
          unique case (op)
            fcc_pkg::CMD_NOP: begin
            end
            fcc_pkg::CMD_PAGE_SELECT: begin
              page_offset_next = page_sel;
            end
            fcc_pkg::CMD_ERASE_MODE: begin
              mode_next       = fcc_pkg::MODE_ERASE;
              status_reg_next = fcc_pkg::STATUS_ERASE_MODE;
            end
            fcc_pkg::CMD_ERASE_PAGE: begin
              page_offset_next = page_sel;
              status_reg_next  = fcc_pkg::STATUS_ERASE_PAGE;
            end
            fcc_pkg::CMD_PROG_MODE: begin
              mode_next = fcc_pkg::MODE_PROGRAM;
            end
            fcc_pkg::CMD_EXECUTE: begin
              if (mode == fcc_pkg::MODE_ERASE) begin
                result.action       = fcc_pkg::ACT_ERASE;
                result.flash_offset = page_offset;
                result.out_length   = fcc_pkg::LEN_W'(fcc_pkg::PAGE_BYTES);
              end else if (mode == fcc_pkg::MODE_PROGRAM) begin
                result.action       = fcc_pkg::ACT_PROGRAM;
                result.flash_offset = page_offset;
                result.mem_pointer  = staging_pointer;
                result.out_length   = fcc_pkg::LEN_W'(fcc_pkg::PAGE_BYTES);
              end
              mode_next = fcc_pkg::MODE_IDLE;
            end
            fcc_pkg::CMD_STATUS_MODE: begin
              mode_next       = fcc_pkg::MODE_STATUS;
              status_reg_next = fcc_pkg::STATUS_STATUS;
            end
            fcc_pkg::CMD_READ_MODE: begin
              mode_next       = fcc_pkg::MODE_READ;
              status_reg_next = fcc_pkg::STATUS_READ;
            end
            default: begin
              result.action = fcc_pkg::ACT_IGNORED;
            end
          endcase
        end
      end
      fcc_pkg::KIND_DMA_TO_FLASH: begin
        if (mode == fcc_pkg::MODE_PROGRAM) begin
          staging_pointer_next = item.mem_address;
        end else begin
          result.action = fcc_pkg::ACT_IGNORED;
        end
      end
      fcc_pkg::KIND_DMA_TO_MEM: begin
        if (mode == fcc_pkg::MODE_STATUS) begin
          result.action      = fcc_pkg::ACT_STATUS_DMA;
          result.data_word   = status_reg;
          result.mem_pointer = item.mem_address;
        end else if (mode == fcc_pkg::MODE_READ) begin
          result.action       = fcc_pkg::ACT_ARRAY_READ;
          result.flash_offset = fcc_pkg::OFFSET_W'({item.flash_address, 1'b0});
          result.mem_pointer  = item.mem_address;
          result.out_length   = item.xfer_length;
        end else begin
          result.action = fcc_pkg::ACT_IGNORED;
        end
      end
      default: begin
        result.action = fcc_pkg::ACT_IGNORED;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode            <= fcc_pkg::MODE_IDLE;
      status_reg      <= '0;
      page_offset     <= '0;
      staging_pointer <= '0;
      accessed        <= 1'b0;
    end else if (advance) begin
      mode            <= mode_next;
      status_reg      <= status_reg_next;
      page_offset     <= page_offset_next;
      staging_pointer <= staging_pointer_next;
      accessed        <= accessed_next;
    end
  end

endmodule

/* hw/rtl/fcc_out_stage.sv */
// result register on the output stream
module fcc_out_stage (
  input  logic             clk,
  input  logic             rst,
  input  logic             load,
  input  fcc_pkg::result_t result_in,
  output logic             ready,
  output logic             m_valid,
  input  logic             m_ready,
  output fcc_pkg::result_t result
);

  assign ready = !m_valid || m_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid <= 1'b0;
    end else if (ready) begin
      m_valid <= load;
    end
    if (load && ready) begin
      result <= result_in;
    end
  end

endmodule
